// File: hw/rtl/rit_pkg.sv
// shared types, codes and helpers for the ranged integer token parser
// no dependencies; used by rit_char_step, rit_finish and the top level

package rit_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned MAG_W   = 64;
    localparam int unsigned BASE_W  = 6;
    localparam int unsigned DIGIT_W = 6;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [MAG_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [MAG_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 2'd2;

    // base values with a meaning of their own
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd36;

    // characters of interest
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;

    typedef enum logic [2:0] {
        PH_WS     = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_PREFIX = 3'd3,
        PH_DIGITS = 3'd4,
        PH_TAIL   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SYNTAX   = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_RANGE    = 3'd3,
        ST_BASE     = 3'd4
    } status_t;

    // running token state
    typedef struct packed {
        phase_t             phase;
        logic               negative;
        logic [MAG_W-1:0]   magnitude;
        logic               overflowed;
        logic [BASE_W-1:0]  eff_base;
        logic               digit_seen;
        logic               trailing_bad;
    } tok_state_t;

    // token state frozen after the last word, handed to the finish stage
    typedef struct packed {
        logic               negative;
        logic [MAG_W-1:0]   magnitude;
        logic               overflowed;
        logic [BASE_W-1:0]  eff_base;
        logic               digit_seen;
        logic               trail;
        logic               in_ws;
    } fin_state_t;

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = CHAR_W'(DIGIT_NONE);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = c - CH_LO_A + 8'd10;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A + 8'd10;
        end
        return d[DIGIT_W-1:0];
    endfunction

    function automatic logic base_invalid(input logic [BASE_W-1:0] b);
        return (b == BASE_ONE) || (b > BASE_MAX);
    endfunction

endpackage

// File: hw/rtl/ranged_integer_token_parser_core.sv
// ranged integer token parser: one character word per cycle while the result side keeps up, one result per token
// the last word of a token passes the input, finish and output registers on its way to the result word
// throughput: one input word every cycle, back-to-back tokens included, while m_tready does not stall the output
// each character is stepped by a combinational multiply-add on the running magnitude
// reset: aresetn synchronous active low; clears token state and pipeline, loads
// min -2^63, max 2^63-1, radix 0 (auto)

module ranged_integer_token_parser_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] char_code
    input  logic                              s_tuser,   // [0] char_present
    input  logic                              s_tlast,   // is_last
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [71:0]                       m_tdata,   // [0] accepted, [64:1] value,
                                                         // [67:65] status, [71:68] zero
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [rit_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [rit_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    // configuration registers
    logic [rit_pkg::MAG_W-1:0]   min_value_reg;
    logic [rit_pkg::MAG_W-1:0]   max_value_reg;
    logic [rit_pkg::BASE_W-1:0]  radix_reg;

    // input stage
    logic                        in_valid_reg;
    logic [rit_pkg::CHAR_W-1:0]  in_char_reg;
    logic                        in_present_reg;
    logic                        in_last_reg;

    // running token state
    rit_pkg::tok_state_t         tok_reg;
    rit_pkg::tok_state_t         tok_next;
    rit_pkg::tok_state_t         tok_step;
    rit_pkg::tok_state_t         tok_after;

    // finish stage
    logic                        fin_valid_reg;
    rit_pkg::fin_state_t         fin_reg;
    rit_pkg::fin_state_t         fin_next;

    // output register
    logic                        out_valid_reg;
    logic                        out_accepted_reg;
    logic [rit_pkg::MAG_W-1:0]   out_value_reg;
    rit_pkg::status_t            out_status_reg;

    logic                        fin_accepted;
    logic [rit_pkg::MAG_W-1:0]   fin_value;
    rit_pkg::status_t            fin_status;

    // stage handshakes
    logic                        out_free;
    logic                        fin_free;
    logic                        in_adv;
    logic                        fin_load;

    assign out_free = !out_valid_reg || m_tready;
    assign fin_free = !fin_valid_reg || out_free;
    // words that do not end a token never need the finish stage
    assign in_adv   = in_valid_reg && (!in_last_reg || fin_free);
    assign fin_load = in_adv && in_last_reg;
    assign s_tready = !in_valid_reg || in_adv;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_value_reg <= rit_pkg::NEG_LIMIT;
            max_value_reg <= rit_pkg::POS_LIMIT;
            radix_reg     <= rit_pkg::BASE_AUTO;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                rit_pkg::CFG_MIN_VALUE: min_value_reg <= cfg_wr_data;
                rit_pkg::CFG_MAX_VALUE: max_value_reg <= cfg_wr_data;
                rit_pkg::CFG_RADIX:     radix_reg     <= cfg_wr_data[rit_pkg::BASE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // input register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_last_reg    <= s_tlast;
        end
    end

    // ---------------------------------------------------------------
    // character step on the registered word
    // ---------------------------------------------------------------
    rit_char_step u_step (
        .cur       (tok_reg),
        .char_code (in_char_reg),
        .radix     (radix_reg),
        .nxt       (tok_step)
    );

    // a word without a character leaves the token untouched
    assign tok_after = in_present_reg ? tok_step : tok_reg;

    always_comb begin
        tok_next = tok_reg;
        if (in_adv) begin
            if (in_last_reg) begin
                // token done: start over for the next one
                tok_next = '{phase: rit_pkg::PH_WS, negative: 1'b0, magnitude: '0,
                             overflowed: 1'b0, eff_base: '0, digit_seen: 1'b0,
                             trailing_bad: 1'b0};
            end else begin
                tok_next = tok_after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '{phase: rit_pkg::PH_WS, negative: 1'b0, magnitude: '0,
                         overflowed: 1'b0, eff_base: '0, digit_seen: 1'b0,
                         trailing_bad: 1'b0};
        end else begin
            tok_reg <= tok_next;
        end
    end

    // snapshot of the token after its last word
    always_comb begin
        fin_next.negative   = tok_after.negative;
        fin_next.magnitude  = tok_after.magnitude;
        fin_next.overflowed = tok_after.overflowed;
        fin_next.eff_base   = tok_after.eff_base;
        fin_next.digit_seen = tok_after.digit_seen;
        // a bare 0x prefix counts as trailing text
        fin_next.trail      = tok_after.trailing_bad || (tok_after.phase == rit_pkg::PH_PREFIX);
        fin_next.in_ws      = (tok_after.phase == rit_pkg::PH_WS);
    end

    // ---------------------------------------------------------------
    // finish stage
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (fin_free) begin
            fin_valid_reg <= fin_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_load) begin
            fin_reg <= fin_next;
        end
    end

    rit_finish u_finish (
        .fin       (fin_reg),
        .radix     (radix_reg),
        .min_value (min_value_reg),
        .max_value (max_value_reg),
        .accepted  (fin_accepted),
        .value     (fin_value),
        .status    (fin_status)
    );

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fin_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && fin_valid_reg) begin
            out_accepted_reg <= fin_accepted;
            out_value_reg    <= fin_value;
            out_status_reg   <= fin_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_status_reg, out_value_reg, out_accepted_reg};

endmodule

// File: hw/rtl/rit_char_step.sv
// one character step of the token parser: phase update and digit accumulation
// depends on rit_pkg

module rit_char_step (
    input  rit_pkg::tok_state_t           cur,
    input  logic [rit_pkg::CHAR_W-1:0]    char_code,
    input  logic [rit_pkg::BASE_W-1:0]    radix,
    output rit_pkg::tok_state_t           nxt
);

    localparam int unsigned PROD_W = rit_pkg::MAG_W + rit_pkg::BASE_W;

    logic                          is_space;
    logic                          start;
    logic [rit_pkg::BASE_W-1:0]    start_base;
    logic                          dig_go;
    logic [rit_pkg::BASE_W-1:0]    dig_base;
    logic [rit_pkg::DIGIT_W-1:0]   digit;
    logic [PROD_W-1:0]             prod;
    logic [PROD_W-1:0]             acc;
    logic                          acc_over;

    assign is_space = (char_code == rit_pkg::CH_SPACE) ||
                      (char_code >= rit_pkg::CH_TAB && char_code <= rit_pkg::CH_CR);
    assign digit    = rit_pkg::digit_of(char_code);

    always_comb begin
        nxt        = cur;
        start      = 1'b0;
        start_base = cur.eff_base;
        dig_go     = 1'b0;
        dig_base   = cur.eff_base;

        case (cur.phase)
            rit_pkg::PH_WS: begin
                if (!is_space) begin
                    nxt.eff_base = radix;
                    if (rit_pkg::base_invalid(radix)) begin
                        nxt.phase = rit_pkg::PH_TAIL;
                    end else if (char_code == rit_pkg::CH_PLUS ||
                                 char_code == rit_pkg::CH_MINUS) begin
                        nxt.negative = (char_code == rit_pkg::CH_MINUS);
                        nxt.phase    = rit_pkg::PH_SIGNED;
                    end else begin
                        start      = 1'b1;
                        start_base = radix;
                    end
                end
            end
            rit_pkg::PH_SIGNED: begin
                start = 1'b1;
            end
            rit_pkg::PH_ZERO: begin
                if (char_code == rit_pkg::CH_LO_X || char_code == rit_pkg::CH_UP_X) begin
                    nxt.eff_base = rit_pkg::BASE_HEX;
                    nxt.phase    = rit_pkg::PH_PREFIX;
                end else begin
                    dig_go   = 1'b1;
                    dig_base = (cur.eff_base == rit_pkg::BASE_AUTO) ?
                               rit_pkg::BASE_OCT : cur.eff_base;
                    nxt.eff_base = dig_base;
                end
            end
            rit_pkg::PH_PREFIX, rit_pkg::PH_DIGITS: begin
                dig_go = 1'b1;
            end
            default: begin
            end
        endcase

        // start of the number: a leading zero may open a prefix or octal
        if (start) begin
            if (char_code == rit_pkg::CH_ZERO &&
                (start_base == rit_pkg::BASE_AUTO || start_base == rit_pkg::BASE_HEX)) begin
                nxt.digit_seen = 1'b1;
                nxt.phase      = rit_pkg::PH_ZERO;
            end else begin
                dig_go   = 1'b1;
                dig_base = (start_base == rit_pkg::BASE_AUTO) ?
                           rit_pkg::BASE_DEC : start_base;
                nxt.eff_base = dig_base;
            end
        end

        // multiply-add with the overflow test as a compare against 2^63
        prod     = PROD_W'(cur.magnitude) * PROD_W'(dig_base);
        acc      = prod + PROD_W'(digit);
        acc_over = acc > PROD_W'(rit_pkg::NEG_LIMIT);

        if (dig_go) begin
            if (dig_base >= 6'd2 && digit < dig_base) begin
                nxt.digit_seen = 1'b1;
                nxt.phase      = rit_pkg::PH_DIGITS;
                if (!cur.overflowed) begin
                    if (acc_over) begin
                        nxt.overflowed = 1'b1;
                    end else begin
                        nxt.magnitude = acc[rit_pkg::MAG_W-1:0];
                    end
                end
            end else begin
                nxt.trailing_bad = 1'b1;
                nxt.phase        = rit_pkg::PH_TAIL;
            end
        end
    end

endmodule

// File: hw/rtl/rit_finish.sv
// end-of-token evaluation: clamping, sign, range check and status priority
// depends on rit_pkg

module rit_finish (
    input  rit_pkg::fin_state_t           fin,
    input  logic [rit_pkg::BASE_W-1:0]    radix,
    input  logic [rit_pkg::MAG_W-1:0]     min_value,
    input  logic [rit_pkg::MAG_W-1:0]     max_value,
    output logic                          accepted,
    output logic [rit_pkg::MAG_W-1:0]     value,
    output rit_pkg::status_t              status
);

    logic [rit_pkg::BASE_W-1:0] base;
    logic [rit_pkg::MAG_W-1:0]  signed_val;
    logic                       below_min;
    logic                       above_max;

    assign base       = fin.in_ws ? radix : fin.eff_base;
    assign signed_val = fin.negative ? (rit_pkg::MAG_W'(0) - fin.magnitude) : fin.magnitude;
    assign below_min  = $signed(signed_val) < $signed(min_value);
    assign above_max  = $signed(max_value) < $signed(signed_val);

    always_comb begin
        value  = '0;
        status = rit_pkg::ST_OK;
        if (rit_pkg::base_invalid(base)) begin
            status = rit_pkg::ST_BASE;
        end else if (!fin.digit_seen) begin
            status = rit_pkg::ST_SYNTAX;
        end else if (fin.negative && (fin.overflowed || fin.magnitude > rit_pkg::NEG_LIMIT)) begin
            value  = rit_pkg::NEG_LIMIT;
            status = rit_pkg::ST_OVERFLOW;
        end else if (!fin.negative &&
                     (fin.overflowed || fin.magnitude > rit_pkg::POS_LIMIT)) begin
            value  = rit_pkg::POS_LIMIT;
            status = rit_pkg::ST_OVERFLOW;
        end else begin
            value = signed_val;
            if (below_min || above_max) begin
                status = rit_pkg::ST_RANGE;
            end else if (fin.trail) begin
                status = rit_pkg::ST_SYNTAX;
            end
        end
    end

    assign accepted = (status == rit_pkg::ST_OK);

endmodule

// File: bench/tb_ranged_integer_token_parser_core.sv
// self-checking bench for ranged_integer_token_parser_core: directed tokens, then random traffic
// depends on rit_pkg and the core rtl; predicts each result word and compares it field by field

module tb_ranged_integer_token_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rit_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    // settle margin before touching the registers
    localparam int HOLDOFF     = 6;
    localparam int REPORT_MAX  = 10;
    localparam logic [BASE_W-1:0] MIN_BASE = 6'd2;

    typedef logic [7:0] text_t[$];

    // one expected result word
    typedef struct packed {
        logic        accepted;
        logic [63:0] value;
        status_t     status;
    } verdict_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] char_code
    logic        s_tuser;    // [0] char_present
    logic        s_tlast;    // is_last
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;    // [0] accepted, [64:1] value, [67:65] status, [71:68] zero
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    ranged_integer_token_parser_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    // register shadows as the parser sees them
    logic [63:0]       lim_lo;
    logic [63:0]       lim_hi;
    logic [BASE_W-1:0] cfg_radix;

    // token in flight, as the parser should hold it
    phase_t            tok_phase;
    logic              tok_neg;
    logic [63:0]       tok_mag;
    logic              tok_ovf;
    logic [BASE_W-1:0] tok_base;
    logic              tok_digit;
    logic              tok_trail;

    verdict_t verdict_q[$];

    int error_count  = 0;
    int results_seen = 0;
    int words_sent   = 0;
    int cycle_count  = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // token conversion predictor
    // ------------------------------------------------------------------

    function automatic logic [DIGIT_W-1:0] char_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return DIGIT_W'(c - CH_ZERO);
        if (c >= CH_LO_A && c <= CH_LO_Z) return DIGIT_W'(c - CH_LO_A + 8'd10);
        if (c >= CH_UP_A && c <= CH_UP_Z) return DIGIT_W'(c - CH_UP_A + 8'd10);
        return DIGIT_NONE;
    endfunction

    function automatic logic radix_bad(input logic [BASE_W-1:0] b);
        return (b == BASE_ONE) || (b > BASE_MAX);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic clear_token();
        tok_phase = PH_WS;
        tok_neg   = 1'b0;
        tok_mag   = '0;
        tok_ovf   = 1'b0;
        tok_base  = BASE_AUTO;
        tok_digit = 1'b0;
        tok_trail = 1'b0;
    endtask

    // multiply-add of one digit, or the start of trailing text
    task automatic accum_digit(input logic [7:0] c);
        logic [DIGIT_W-1:0] d;
        d = char_value(c);
        if (tok_base >= MIN_BASE && d < tok_base) begin
            tok_digit = 1'b1;
            tok_phase = PH_DIGITS;
            if (!tok_ovf) begin
                if (tok_mag > (NEG_LIMIT - d) / tok_base)
                    tok_ovf = 1'b1;
                else
                    tok_mag = tok_mag * tok_base + d;
            end
        end else begin
            tok_trail = 1'b1;
            tok_phase = PH_TAIL;
        end
    endtask

    // first character of the number, after any sign; a leading zero may open a prefix
    task automatic start_number(input logic [7:0] c);
        if (c == CH_ZERO && (tok_base == BASE_AUTO || tok_base == BASE_HEX)) begin
            tok_digit = 1'b1;
            tok_phase = PH_ZERO;
        end else begin
            if (tok_base == BASE_AUTO) tok_base = BASE_DEC;
            accum_digit(c);
        end
    endtask

    task automatic take_char(input logic [7:0] c);
        case (tok_phase)
            PH_WS: begin
                if (!is_blank(c)) begin
                    // radix is latched on the first non-blank character
                    tok_base = cfg_radix;
                    if (radix_bad(tok_base)) begin
                        tok_phase = PH_TAIL;
                    end else if (c == CH_PLUS || c == CH_MINUS) begin
                        tok_neg   = (c == CH_MINUS);
                        tok_phase = PH_SIGNED;
                    end else begin
                        start_number(c);
                    end
                end
            end
            PH_SIGNED: start_number(c);
            PH_ZERO: begin
                if (c == CH_LO_X || c == CH_UP_X) begin
                    tok_base  = BASE_HEX;
                    tok_phase = PH_PREFIX;
                end else begin
                    if (tok_base == BASE_AUTO) tok_base = BASE_OCT;
                    accum_digit(c);
                end
            end
            PH_PREFIX: begin
                if (char_value(c) < BASE_HEX) begin
                    accum_digit(c);
                end else begin
                    tok_trail = 1'b1;
                    tok_phase = PH_TAIL;
                end
            end
            PH_DIGITS: accum_digit(c);
            default: ;
        endcase
    endtask

    // end of token: judge it and queue the expected result word
    task automatic close_token();
        verdict_t          v;
        logic [BASE_W-1:0] b;
        logic              trail;
        b     = (tok_phase == PH_WS) ? cfg_radix : tok_base;
        trail = tok_trail || (tok_phase == PH_PREFIX);
        v.value = '0;
        if (radix_bad(b)) begin
            v.status = ST_BASE;
        end else if (!tok_digit) begin
            v.status = ST_SYNTAX;
        end else if (tok_neg && (tok_ovf || tok_mag > NEG_LIMIT)) begin
            v.value  = NEG_LIMIT;
            v.status = ST_OVERFLOW;
        end else if (!tok_neg && (tok_ovf || tok_mag > POS_LIMIT)) begin
            v.value  = POS_LIMIT;
            v.status = ST_OVERFLOW;
        end else begin
            v.value = tok_neg ? (64'd0 - tok_mag) : tok_mag;
            if ($signed(v.value) < $signed(lim_lo) || $signed(lim_hi) < $signed(v.value))
                v.status = ST_RANGE;
            else if (trail)
                v.status = ST_SYNTAX;
            else
                v.status = ST_OK;
        end
        v.accepted = (v.status == ST_OK);
        verdict_q.push_back(v);
        clear_token();
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one input word; predictor runs at the accepting edge
    task automatic send_word(input logic [7:0] c, input logic present, input logic last);
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        s_tuser  = present;
        s_tlast  = last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (present) take_char(c);
        if (last) close_token();
        if (present || last) words_sent++;
    endtask

    // characters of one token, with an occasional ignored word mixed in;
    // blank_end closes the token with a word that carries no character
    task automatic send_token(input text_t txt, input bit blank_end);
        int n;
        n = txt.size();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 4)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(txt[i], 1'b1, (i == n - 1) && !blank_end);
        end
        if (blank_end || n == 0)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    function automatic text_t to_text(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
        return t;
    endfunction

    task automatic send_text(input string s);
        send_token(to_text(s), 1'b0);
    endtask

    // sender stops until every pending result has come back, then lets the pipe settle
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (verdict_q.size() != 0) @(negedge aclk);
        repeat (HOLDOFF) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge aclk);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = data;
        @(posedge aclk);
        case (idx)
            CFG_MIN_VALUE: lim_lo = data;
            CFG_MAX_VALUE: lim_hi = data;
            CFG_RADIX:     cfg_radix = data[BASE_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [BASE_W-1:0] rdx);
        drain_results();
        write_reg(CFG_MIN_VALUE, lo);
        write_reg(CFG_MAX_VALUE, hi);
        write_reg(CFG_RADIX, {{(64 - BASE_W){1'b0}}, rdx});
    endtask

    // ------------------------------------------------------------------
    // random token text
    // ------------------------------------------------------------------

    function automatic logic [7:0] digit_char(input int v);
        if (v < 10) return 8'(CH_ZERO + v);
        if ($urandom_range(0, 1)) return 8'(CH_LO_A + v - 10);
        return 8'(CH_UP_A + v - 10);
    endfunction

    // mostly well-formed numbers in the current radix, some noise and damage
    task automatic compose_token(output text_t txt);
        int ndig;
        int b;
        txt = {};
        if ($urandom_range(0, 99) < 10) begin
            repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3))
                txt.push_back($urandom_range(0, 5) == 0 ?
                              CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
        end
        case ($urandom_range(0, 2))
            1: txt.push_back(CH_PLUS);
            2: txt.push_back(CH_MINUS);
            default: ;
        endcase
        // mostly short numbers, some long enough to overflow
        case ($urandom_range(0, 9))
            0:       ndig = $urandom_range(16, 70);
            1, 2:    ndig = $urandom_range(5, 15);
            default: ndig = $urandom_range(1, 4);
        endcase
        b = cfg_radix;
        if (cfg_radix == BASE_AUTO) begin
            case ($urandom_range(0, 2))
                0: begin
                    b = BASE_DEC;
                    txt.push_back(digit_char($urandom_range(1, 9)));
                    ndig--;
                end
                1: begin
                    b = BASE_OCT;
                    txt.push_back(CH_ZERO);
                end
                default: begin
                    b = BASE_HEX;
                    txt.push_back(CH_ZERO);
                    txt.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                    // bare prefix now and then
                    if ($urandom_range(0, 7) == 0) ndig = 0;
                end
            endcase
        end else if (cfg_radix == BASE_HEX && $urandom_range(0, 1)) begin
            txt.push_back(CH_ZERO);
            txt.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        end else if (radix_bad(cfg_radix)) begin
            b = BASE_DEC;
        end
        repeat (ndig) txt.push_back(digit_char($urandom_range(0, b - 1)));
        // trailing text, then a stray byte somewhere
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) == 0)
            txt.insert($urandom_range(0, txt.size()), 8'($urandom_range(0, 255)));
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct,
                                    input logic [63:0] lo, input logic [63:0] hi,
                                    input logic [BASE_W-1:0] rdx, input int count);
        text_t txt;
        int    goal;
        bit    paused;
        set_config(lo, hi, rdx);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        goal   = words_sent + count;
        paused = 1'b0;
        while (words_sent < goal) begin
            compose_token(txt);
            send_token(txt, $urandom_range(0, 9) == 0);
            // halfway through, let the result side empty out completely
            if (!paused && words_sent >= goal - count / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty token, blanks only, lone signs, zero byte, blank closing word
    task automatic test_empty_and_blank();
        text_t zb;
        zb.push_back(8'h00);
        send_text("");
        send_text(" \t\r\n");
        send_text("+");
        send_text("-");
        send_token(zb, 1'b0);
        send_token(to_text("7"), 1'b1);
    endtask

    // auto radix: decimal, octal, hex prefix, bare prefix, trailing text, limits and overflow
    task automatic test_auto_radix();
        send_text("42");
        send_text(" -017");
        send_text("0x1F");
        send_text("0");
        send_text("0x");
        send_text("0xg");
        send_text("12ab");
        send_text("9223372036854775807");
        send_text("-9223372036854775808");
        send_text("9223372036854775808");
        send_text("-9223372036854775809");
    endtask

    // invalid radix values, smallest and largest bases, hex with prefix
    task automatic test_radix_limits();
        set_config(NEG_LIMIT, POS_LIMIT, BASE_ONE);
        send_text("5");
        set_config(NEG_LIMIT, POS_LIMIT, 6'd63);
        send_text(" -5");
        set_config(NEG_LIMIT, POS_LIMIT, 6'd37);
        send_text(" ");
        set_config(NEG_LIMIT, POS_LIMIT, MIN_BASE);
        send_text("-101");
        send_text("12");
        set_config(NEG_LIMIT, POS_LIMIT, BASE_MAX);
        send_text("Zz");
        set_config(NEG_LIMIT, POS_LIMIT, BASE_HEX);
        send_text("0X1g");
        send_text("0x");
    endtask

    // single-value window: in range, both sides out, range beats trailing text
    task automatic test_range_limits();
        set_config(64'd5, 64'd5, BASE_DEC);
        send_text("5");
        send_text("6");
        send_text("4x");
        send_text("5x");
    endtask

    task automatic test_random_traffic();
        longint lo;
        longint hi;
        logic [63:0] wide_a;
        logic [63:0] wide_b;
        wide_a = {$urandom, $urandom};
        wide_b = {$urandom, $urandom};
        lo = -longint'($urandom_range(0, 5000));
        hi = longint'($urandom_range(0, 5000));
        // sender rarely idle, receiver mostly stalled
        run_random_phase(6, 79, NEG_LIMIT, POS_LIMIT, BASE_AUTO, 125);
        run_random_phase(6, 79, -64'sd1000, 64'sd1000, BASE_DEC, 125);
        // sender mostly idle, receiver rarely stalled
        run_random_phase(79, 6, wide_a, wide_b, BASE_HEX, 125);
        run_random_phase(79, 6, 64'd0, POS_LIMIT, 6'($urandom_range(2, 36)), 125);
        // full rate both sides
        run_random_phase(0, 0, NEG_LIMIT, 64'd0, BASE_OCT, 125);
        run_random_phase(0, 0, lo, hi, BASE_AUTO, 125);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= REPORT_MAX) $display("ERROR @%0t: %s", $time, msg);
    endtask

    // receiver stall pattern, changed on the falling edge
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        verdict_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                flag_error($sformatf("result word %0d with nothing pending: %h",
                                     results_seen, m_tdata));
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want.accepted)
                    flag_error($sformatf("word %0d accepted: expected %b got %b",
                                         results_seen, want.accepted, m_tdata[0]));
                if (m_tdata[64:1] !== want.value)
                    flag_error($sformatf("word %0d value: expected %h got %h",
                                         results_seen, want.value, m_tdata[64:1]));
                if (m_tdata[67:65] !== want.status)
                    flag_error($sformatf("word %0d status: expected %0d got %0d",
                                         results_seen, want.status, m_tdata[67:65]));
                if (m_tdata[71:68] !== 4'd0)
                    flag_error($sformatf("word %0d padding: expected 0 got %h",
                                         results_seen, m_tdata[71:68]));
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : main_seq
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = CFG_MIN_VALUE;
        cfg_wr_data  = '0;
        aresetn      = 1'b0;
        // reset values of the registers
        lim_lo    = NEG_LIMIT;
        lim_hi    = POS_LIMIT;
        cfg_radix = BASE_AUTO;
        clear_token();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed part runs on the reset register values first
        src_idle_pct  = 6;
        sink_idle_pct = 79;
        test_empty_and_blank();
        test_auto_radix();
        test_radix_limits();
        test_range_limits();
        test_random_traffic();

        drain_results();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
